@@ rtl/dejittered_seven_segment_scan_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the seven-segment scan driver.
// The macros expect clk and rst to be in scope where they are used.
// ----------------------------------------------------------------------------
`ifndef DEJITTERED_SEVEN_SEGMENT_SCAN_MACROS_SVH
`define DEJITTERED_SEVEN_SEGMENT_SCAN_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dss_pkg.sv @@
// ----------------------------------------------------------------------------
// dss_pkg
// Types, constants and decode functions shared by the scan driver modules.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int SampleW = 10;
  localparam int SelW    = 6;
  localparam int SegW    = 8;
  localparam int DigitW  = 4;

  localparam logic [SampleW-1:0] SampleMax     = 10'd1023;
  localparam logic [SelW-1:0]    BlankSelect   = 6'd0;
  localparam logic [SegW-1:0]    BlankSegments = 8'hFF;

  // Number of digits in the run.
  typedef enum logic [1:0] {
    RUN_ONE   = 2'd0,
    RUN_TWO   = 2'd1,
    RUN_THREE = 2'd2,
    RUN_FOUR  = 2'd3
  } run_kind_t;

  // One queued display run: digit 0 is the ones digit.
  typedef struct packed {
    run_kind_t                   kind;
    logic [3:0][DigitW-1:0]      digits;
  } run_t;

  typedef struct packed {
    logic [SelW-1:0] digit_select;
    logic [SegW-1:0] segments;
    logic            last;
  } result_t;

  function automatic logic [SegW-1:0] seg_pattern(input logic [DigitW-1:0] d);
    logic [SegW-1:0] p;
    unique case (d)
      4'd0:    p = 8'hC0;
      4'd1:    p = 8'hF9;
      4'd2:    p = 8'hA4;
      4'd3:    p = 8'hB0;
      4'd4:    p = 8'h99;
      4'd5:    p = 8'h92;
      4'd6:    p = 8'h82;
      4'd7:    p = 8'hF8;
      4'd8:    p = 8'h80;
      4'd9:    p = 8'h90;
      default: p = BlankSegments;
    endcase
    return p;
  endfunction

  function automatic logic [SelW-1:0] enable_code(input logic [1:0] pos);
    logic [SelW-1:0] e;
    unique case (pos)
      2'd0:    e = 6'h02;
      2'd1:    e = 6'h04;
      2'd2:    e = 6'h10;
      default: e = 6'h20;
    endcase
    return e;
  endfunction

  // Result at position idx of a run. Short values show the digit alone;
  // two-digit values are framed by blanks; longer ones put a blank after
  // each digit.
  function automatic result_t result_at(input run_t run, input logic [2:0] idx);
    logic       is_digit;
    logic [1:0] pos;
    logic [2:0] last_idx;
    result_t    r;
    unique case (run.kind)
      RUN_ONE: begin
        is_digit = 1'b1;
        pos      = 2'd0;
        last_idx = 3'd0;
      end
      RUN_TWO: begin
        is_digit = idx[0];
        pos      = {1'b0, idx[1]};
        last_idx = 3'd4;
      end
      RUN_THREE: begin
        is_digit = ~idx[0];
        pos      = idx[2:1];
        last_idx = 3'd5;
      end
      default: begin
        is_digit = ~idx[0];
        pos      = idx[2:1];
        last_idx = 3'd7;
      end
    endcase
    if (is_digit) begin
      r.digit_select = enable_code(pos);
      r.segments     = seg_pattern(run.digits[pos]);
    end else begin
      r.digit_select = BlankSelect;
      r.segments     = BlankSegments;
    end
    r.last = (idx == last_idx);
    return r;
  endfunction

endpackage

@@ rtl/dejittered_seven_segment_scan.sv @@
// ----------------------------------------------------------------------------
// dejittered_seven_segment_scan
// Dejittered multiplexed seven-segment scan driver.
// ----------------------------------------------------------------------------
// Usage: the sample channel is a queue write port. A 10-bit reading is taken
// on a clock edge where push is high and full is low. The result channel is a
// queue read port: while empty is low the oldest word (digit_select,
// segments, last) sits on the ports, and it leaves on an edge where pop is
// high. Each sample produces a run of 1, 5, 6 or 8 words, one per cycle while
// the receiver keeps popping, and last marks the final word of the run.
// Path: a sample passes through the input stage, then the run queue, then
// the output register, where the words of its run appear.
// Throughput: the back end emits one word per cycle while the receiver pops
// or the output register is empty; the front end accepts one sample per cycle
// while the two-entry run queue has room.
// Reset: rst clears the last shown value to zero and empties every stage.
// Stalls: if the receiver holds pop low, the output word holds, the back end
// stops stepping, the queue fills and full then rises on the input side.
// ----------------------------------------------------------------------------
module dejittered_seven_segment_scan
  import dss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [SampleW-1:0] sample,
  output logic               empty,
  input  logic               pop,
  output logic [SelW-1:0]    digit_select,
  output logic [SegW-1:0]    segments,
  output logic               last
);

  // Front to queue.
  logic f_push;
  run_t f_data;
  logic q_full;

  // Queue to back.
  logic q_valid;
  run_t q_data;
  logic q_pop;

  // The front end decides what value is shown and how the run is laid out.
  dss_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .sample (sample),
    .q_push (f_push),
    .q_data (f_data),
    .q_full (q_full)
  );

  // A short queue decouples classification from the per-word scan.
  dss_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (f_push),
    .wr_data (f_data),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_data (q_data)
  );

  // The back end walks the run and retires it with its final word.
  dss_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .digit_select (digit_select),
    .segments     (segments),
    .last         (last)
  );

endmodule

@@ rtl/dss_front.sv @@
// ----------------------------------------------------------------------------
// dss_front
// Takes samples, applies the one-count dejitter against the last shown
// value, splits the shown value into decimal digits and classifies the run.
// ----------------------------------------------------------------------------
`include "dejittered_seven_segment_scan_macros.svh"

module dss_front
  import dss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [SampleW-1:0] sample,
  output logic               q_push,
  output run_t               q_data,
  input  logic               q_full
);

  logic               s1_valid;
  logic [SampleW-1:0] s1_value;
  logic [SampleW-1:0] prev_value;
  logic [SampleW-1:0] shown;
  logic               advance;
  logic               accept;

  logic [9:0] r1;
  logic [6:0] r2;
  logic [3:0] r3;
  logic [3:0] thou;
  logic [3:0] hund;
  logic [3:0] tens;

  // The stage moves when it is empty or the queue can take its word.
  assign advance = ~s1_valid | ~q_full;
  assign full    = ~advance;
  assign accept  = push & advance;
  assign q_push  = s1_valid & ~q_full;

  always_comb begin
    shown = sample;
    if (sample != '0 && sample != SampleMax && prev_value != '0) begin
      if ({1'b0, prev_value} == {1'b0, sample} + 11'd1 ||
          {1'b0, prev_value} + 11'd1 == {1'b0, sample}) begin
        shown = prev_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      prev_value <= '0;
    end else if (advance) begin
      s1_valid <= push;
      if (accept) begin
        prev_value <= shown;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value <= shown;
    end
  end

  // Decimal split by parallel threshold compares on each digit.
  always_comb begin
    thou = (s1_value >= 10'd1000) ? 4'd1 : 4'd0;
    r1   = (s1_value >= 10'd1000) ? s1_value - 10'd1000 : s1_value;
    hund = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r1 >= 10'(100 * k)) begin
        hund = 4'(k);
      end
    end
    r2   = 7'(r1 - 10'(hund) * 10'd100);
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r2 >= 7'(10 * k)) begin
        tens = 4'(k);
      end
    end
    r3 = 4'(r2 - 7'(tens) * 7'd10);
  end

  always_comb begin
    q_data.digits = {thou, hund, tens, r3};
    if (s1_value <= 10'd9) begin
      q_data.kind = RUN_ONE;
    end else if (s1_value <= 10'd99) begin
      q_data.kind = RUN_TWO;
    end else if (s1_value <= 10'd999) begin
      q_data.kind = RUN_THREE;
    end else begin
      q_data.kind = RUN_FOUR;
    end
  end

  `DSS_ASSERT_NEXT(a_prev_tracks_stage, accept, s1_valid && prev_value == s1_value,
                   "last shown value does not match the staged value")
  `DSS_ASSERT_NOW(a_no_push_when_full, q_full, !q_push, "front pushed into a full queue")

endmodule

@@ rtl/dss_queue.sv @@
// ----------------------------------------------------------------------------
// dss_queue
// Two-entry queue of display runs between the front and the back.
// ----------------------------------------------------------------------------
`include "dejittered_seven_segment_scan_macros.svh"

module dss_queue
  import dss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  run_t wr_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output run_t rd_data
);

  run_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  `DSS_ASSERT_NOW(a_count_range, 1'b1, count != 2'd3, "queue count out of range")
  `DSS_ASSERT_NOW(a_pop_nonempty, pop, valid, "pop from an empty queue")

endmodule

@@ rtl/dss_back.sv @@
// ----------------------------------------------------------------------------
// dss_back
// Steps through the run at the queue head into an output register, one
// result per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
`include "dejittered_seven_segment_scan_macros.svh"

module dss_back
  import dss_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  run_t            q_data,
  output logic            q_pop,
  output logic            empty,
  input  logic            pop,
  output logic [SelW-1:0] digit_select,
  output logic [SegW-1:0] segments,
  output logic            last
);

  logic    out_valid;
  logic [2:0] idx;
  logic    load;
  result_t res;

  assign res   = result_at(q_data, idx);
  assign load  = q_valid & (~out_valid | pop);
  assign q_pop = load & res.last;
  assign empty = ~out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= res.last ? 3'd0 : idx + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digit_select <= res.digit_select;
      segments     <= res.segments;
      last         <= res.last;
    end
  end

  `DSS_ASSERT_NOW(a_one_digit_idx, q_valid && q_data.kind == RUN_ONE, idx == 3'd0,
                  "single-digit run past its only result")
  `DSS_ASSERT_NOW(a_two_digit_idx, q_valid && q_data.kind == RUN_TWO, idx <= 3'd4,
                  "two-digit run past its last result")
  `DSS_ASSERT_NEXT(a_final_word_shown, q_pop, !empty && last,
                   "run retired without its final word on the output")

endmodule

@@ tb/scan_checker.sv @@
// ----------------------------------------------------------------------------
// Scan checker
// Watches the sample and display channels of the scan driver. It keeps its
// own copy of the last shown value, builds the expected display run for every
// accepted sample and compares each popped word with the oldest expectation.
// ----------------------------------------------------------------------------
module scan_checker
  import dss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic [SampleW-1:0] sample,
  input  logic               empty,
  input  logic               pop,
  input  logic [SelW-1:0]    digit_select,
  input  logic [SegW-1:0]    segments,
  input  logic               last,
  output int unsigned        pending_words,
  output int unsigned        failures
);
  timeunit 1ns;
  timeprecision 1ps;

  // Active-low glyphs for the digits 0 to 9, bits hgfedcba.
  localparam logic [SegW-1:0] DIGIT_GLYPH [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };
  // Digit enables for ones, tens, hundreds and thousands.
  localparam logic [SelW-1:0] PLACE_ENABLE [4] = '{6'h02, 6'h04, 6'h10, 6'h20};
  localparam result_t BLANK_WORD = '{
    digit_select: BlankSelect, segments: BlankSegments, last: 1'b0
  };

  result_t            expected_words[$];
  logic [SampleW-1:0] shown_value = '0;
  int unsigned        words_seen = 0;

  // A sample one step away from a nonzero shown value is treated as jitter,
  // except at the two ends of the converter range.
  function automatic logic [SampleW-1:0] settle_value(
    input logic [SampleW-1:0] s, input logic [SampleW-1:0] p);
    if (s != '0 && s != SampleMax && p != '0 && (p == s + 1 || p + 1 == s))
      return p;
    return s;
  endfunction

  function automatic result_t lit_place(input logic [SampleW-1:0] v,
                                        input int place);
    int unsigned divisor;
    divisor = (place == 0) ? 1 : (place == 1) ? 10 : (place == 2) ? 100 : 1000;
    return '{digit_select: PLACE_ENABLE[place],
             segments: DIGIT_GLYPH[(v / divisor) % 10], last: 1'b0};
  endfunction

  task automatic queue_display_run(input logic [SampleW-1:0] v);
    int n_places;
    if (v <= 9) begin
      expected_words.push_back(lit_place(v, 0));
    end else if (v <= 99) begin
      expected_words.push_back(BLANK_WORD);
      expected_words.push_back(lit_place(v, 0));
      expected_words.push_back(BLANK_WORD);
      expected_words.push_back(lit_place(v, 1));
      expected_words.push_back(BLANK_WORD);
    end else begin
      n_places = (v <= 999) ? 3 : 4;
      for (int i = 0; i < n_places; i++) begin
        expected_words.push_back(lit_place(v, i));
        expected_words.push_back(BLANK_WORD);
      end
    end
    expected_words[expected_words.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      shown_value = '0;
      failures    = 0;
      expected_words.delete();
    end else begin
      // Compare first so that a run queued at this edge lands behind it.
      if (pop && !empty) begin
        got = '{digit_select: digit_select, segments: segments, last: last};
        if (expected_words.size() == 0) begin
          if (failures < 10)
            $display("checker: word %0d popped with nothing expected: sel=%h seg=%h last=%b",
                     words_seen, got.digit_select, got.segments, got.last);
          failures++;
        end else begin
          want = expected_words.pop_front();
          if (got.digit_select != want.digit_select || got.segments != want.segments ||
              got.last != want.last) begin
            if (failures < 10)
              $display("checker: word %0d expected sel=%h seg=%h last=%b, got sel=%h seg=%h last=%b",
                       words_seen, want.digit_select, want.segments, want.last,
                       got.digit_select, got.segments, got.last);
            failures++;
          end
        end
        words_seen++;
      end
      if (push && !full) begin
        shown_value = settle_value(sample, shown_value);
        queue_display_run(shown_value);
      end
    end
    pending_words <= expected_words.size();
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Scan driver testbench
// Feeds converter samples into the dejittered seven-segment scan driver and
// lets a separate checker predict and compare every display word. A directed
// pass covers the range ends, every run length and the jitter rules; random
// samples follow under three idling patterns on the two channels.
// ----------------------------------------------------------------------------
module testbench
  import dss_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_PER_PHASE = 65;
  localparam int          SETTLE_CYCLES    = 12;
  localparam int unsigned CYCLE_LIMIT      = 100000;

  // Directed samples. The order matters: several of them only hit a jitter
  // rule because of the value shown just before.
  localparam logic [SampleW-1:0] DIRECTED_SAMPLES [25] = '{
    10'd0,    // lower end, single digit
    10'd1,    // previous value zero, so shown as is
    10'd2,    // one above the shown 1, held at 1
    10'd0,    // zero is always shown
    10'd1023, // upper end, four digits
    10'd1022, // one below 1023, held
    10'd1022, // still held since the shown value stays 1023
    10'd1021, // two away, shown
    10'd1023, // upper end after a near value
    10'd1000, // smallest four-digit value
    10'd999,  // one below, held at 1000
    10'd998,  // two below the shown 1000, shown
    10'd9,    // largest single digit
    10'd10,   // one above, held at 9
    10'd11,   // two away from 9, two digits
    10'd99,   // largest two-digit value
    10'd100,  // one above, held at 99
    10'd101,  // shown, three digits
    10'd100,  // one below, held at 101
    10'd999,  // largest three-digit value
    10'd1000, // one above, held at 999
    10'd500,
    10'd500,  // equal to the shown value
    10'h2AA,  // alternating bit patterns
    10'h155
  };

  localparam logic [SampleW-1:0] BOUNDARY_VALUES [10] = '{
    10'd0, 10'd1, 10'd9, 10'd10, 10'd99, 10'd100, 10'd999, 10'd1000, 10'd1022,
    10'd1023
  };

  // Idle percentages per random phase: sender first, then receiver.
  localparam int unsigned SEND_IDLE [3] = '{31, 65, 0};
  localparam int unsigned TAKE_IDLE [3] = '{65, 31, 0};

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic [SampleW-1:0] sample;
  logic               empty;
  logic               pop;
  logic [SelW-1:0]    digit_select;
  logic [SegW-1:0]    segments;
  logic               last;

  int unsigned pending_words;
  int unsigned failures;
  int unsigned send_idle_pct = SEND_IDLE[0];
  int unsigned take_idle_pct = TAKE_IDLE[0];

  dejittered_seven_segment_scan dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .sample       (sample),
    .empty        (empty),
    .pop          (pop),
    .digit_select (digit_select),
    .segments     (segments),
    .last         (last)
  );

  scan_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .sample        (sample),
    .empty         (empty),
    .pop           (pop),
    .digit_select  (digit_select),
    .segments      (segments),
    .last          (last),
    .pending_words (pending_words),
    .failures      (failures)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver decides afresh every cycle whether to take a word. With an
  // idle percentage of zero, pop simply stays high.
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      pop <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  // Offers one sample and returns at the edge that takes it. Push is only
  // lowered while the sender idles, so back-to-back words keep push high
  // without a second assignment in the same time step.
  task automatic offer_sample(input logic [SampleW-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push   <= 1'b1;
    sample <= value;
    do @(posedge clk); while (full);
  endtask

  // Holds the sender off until every expected word has come out. The
  // checker's count is registered, so the loop waits for an edge before it looks.
  task automatic drain_display();
    push <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  // About two in five random samples sit at or next to the last one so that the
  // jitter rule is exercised often; the rest are boundary values or spread over the range.
  function automatic logic [SampleW-1:0] pick_sample(input logic [SampleW-1:0] recent);
    int unsigned roll;
    int          step;
    roll = $urandom_range(99);
    if (roll < 40) begin
      step = int'($urandom_range(2)) - 1;
      return SampleW'(recent + step);
    end
    if (roll < 55)
      return BOUNDARY_VALUES[$urandom_range(9)];
    return SampleW'($urandom_range(SampleMax));
  endfunction

  initial begin : stimulus
    logic [SampleW-1:0] recent;
    rst    <= 1'b1;
    push   <= 1'b0;
    sample <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_SAMPLES[i])
      offer_sample(DIRECTED_SAMPLES[i]);
    recent = DIRECTED_SAMPLES[24];
    // Let the whole directed pass drain before the random part starts.
    drain_display();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = SEND_IDLE[phase];
      take_idle_pct = TAKE_IDLE[phase];
      repeat (RANDOM_PER_PHASE) begin
        recent = pick_sample(recent);
        offer_sample(recent);
      end
      drain_display();
    end

    // The settle wait catches any stray word after the last expected one.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && pending_words == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/dss_pkg.sv
rtl/dss_front.sv
rtl/dss_queue.sv
rtl/dss_back.sv
rtl/dejittered_seven_segment_scan.sv
tb/scan_checker.sv
tb/testbench.sv
